[hdl/dgfr_pkg.sv]
// dgfr_pkg: shared constants, codes, digit font and controller/datapath
// interface types for the decimal glyph framebuffer renderer
// no dependencies
`default_nettype none

package dgfr_pkg;

  localparam int ROW_BYTES_DEFAULT       = 64;
  localparam int DISPLAY_COLUMNS_DEFAULT = 128;
  localparam int GLYPH_W                 = 12;
  localparam int GLYPH_BYTES             = 24;
  localparam int NUMBER_MAX              = 999;

  localparam logic [1:0] OP_RENDER = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_IGNORED = 2'd1;
  localparam logic [1:0] STATUS_CLIPPED = 2'd2;

  typedef enum logic [2:0] {
    FIN_NONE,
    FIN_IGNORED,
    FIN_CLEAR,
    FIN_READ,
    FIN_RENDER
  } fin_t;

  typedef struct packed {
    logic clr_step;
    logic rd_read;
    logic dig_hund;
    logic dig_rem;
    logic dig_tens;
    logic dig_ones;
    logic px_rd;
    logic px_wr;
    fin_t fin;
  } dgfr_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic px_last;
  } dgfr_stat_t;

  localparam logic [7:0] DIGIT_FONT [240] = '{
    8'h00, 8'hE0, 8'hF8, 8'h1C, 8'h0E, 8'h06, 8'h06, 8'h0E, 8'h1C, 8'hF8, 8'hE0, 8'h00,
    8'h00, 8'h0F, 8'h3F, 8'h70, 8'hE0, 8'hC0, 8'hC0, 8'hE0, 8'h70, 8'h3F, 8'h0F, 8'h00,
    8'h00, 8'h00, 8'h30, 8'h18, 8'h1C, 8'hFE, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h38, 8'h1C, 8'h0E, 8'h06, 8'h06, 8'h06, 8'h0E, 8'h9C, 8'hF8, 8'h70, 8'h00,
    8'h00, 8'hE0, 8'hF0, 8'hF8, 8'hDC, 8'hCE, 8'hC7, 8'hC3, 8'hC1, 8'hC0, 8'hC0, 8'h00,
    8'h00, 8'h18, 8'h0C, 8'h0E, 8'h86, 8'h86, 8'h86, 8'hCE, 8'hFC, 8'h78, 8'h00, 8'h00,
    8'h00, 8'h30, 8'h60, 8'hE0, 8'hC1, 8'hC1, 8'hC1, 8'hE3, 8'h7F, 8'h3E, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h80, 8'hC0, 8'h60, 8'h30, 8'h18, 8'hFE, 8'hFE, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h0F, 8'h0F, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'hFF, 8'hFF, 8'h0C, 8'h0C, 8'h00,
    8'h00, 8'h00, 8'hFE, 8'hFE, 8'hC6, 8'hC6, 8'hC6, 8'hC6, 8'h86, 8'h06, 8'h00, 8'h00,
    8'h00, 8'h30, 8'h61, 8'hE1, 8'hC1, 8'hC1, 8'hC1, 8'hE3, 8'h7F, 8'h3E, 8'h00, 8'h00,
    8'h00, 8'hE0, 8'hF8, 8'h9C, 8'hCE, 8'hC6, 8'hC6, 8'hC6, 8'h8E, 8'h1C, 8'h00, 8'h00,
    8'h00, 8'h0F, 8'h3F, 8'h71, 8'hE1, 8'hC1, 8'hC1, 8'hE1, 8'h7F, 8'h3F, 8'h00, 8'h00,
    8'h00, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h86, 8'hE6, 8'h7E, 8'h1E, 8'h06, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'hC0, 8'hF8, 8'h3F, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h78, 8'hFC, 8'hCE, 8'h86, 8'h86, 8'h86, 8'hCE, 8'hFC, 8'h78, 8'h00, 8'h00,
    8'h00, 8'h3E, 8'h7F, 8'hE3, 8'hC1, 8'hC1, 8'hC1, 8'hE3, 8'h7F, 8'h3E, 8'h00, 8'h00,
    8'h00, 8'hF8, 8'hFC, 8'h8E, 8'h06, 8'h06, 8'h06, 8'h0E, 8'h9C, 8'hF8, 8'hE0, 8'h00,
    8'h00, 8'h00, 8'hE1, 8'hC3, 8'hC3, 8'hC3, 8'hE7, 8'h7E, 8'h3F, 8'h0F, 8'h01, 8'h00
  };

  function automatic logic [7:0] font_byte(input logic [3:0] digit, input logic [4:0] pos);
    logic [7:0] k;
    k = 8'(digit) * 8'(GLYPH_BYTES) + 8'(pos);
    return DIGIT_FONT[k];
  endfunction

endpackage

`default_nettype wire

[hdl/dgfr_ctrl.sv]
// dgfr_ctrl: sequencer for the glyph renderer; issues datapath commands
// depends on dgfr_pkg
`default_nettype none

module dgfr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [1:0]          op,
  input  wire logic [9:0]          number,
  input  wire logic                ready,
  input  wire dgfr_pkg::dgfr_stat_t stat,
  output dgfr_pkg::dgfr_cmd_t      cmd,
  output logic                     busy
);
  import dgfr_pkg::*;

  typedef enum logic [3:0] {
    INIT,
    IDLE,
    CLEAR,
    CLEAR_DONE,
    READ,
    READ_DONE,
    IGNORE,
    DIG_HUND,
    DIG_REM,
    DIG_TENS,
    DIG_ONES,
    PIX_READ,
    PIX_WRITE,
    RENDER_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= INIT;
    end else begin
      case (state)
        INIT: begin
          if (stat.sweep_last) state <= IDLE;
        end
        IDLE: begin
          if (accept) begin
            case (op)
              OP_READ: state <= READ;
              OP_RENDER: begin
                if (ready && (number <= 10'(NUMBER_MAX))) state <= DIG_HUND;
                else state <= IGNORE;
              end
              OP_CLEAR: begin
                if (ready) state <= CLEAR;
                else state <= IGNORE;
              end
              default: state <= IGNORE;
            endcase
          end
        end
        CLEAR: begin
          if (stat.sweep_last) state <= CLEAR_DONE;
        end
        READ:      state <= READ_DONE;
        DIG_HUND:  state <= DIG_REM;
        DIG_REM:   state <= DIG_TENS;
        DIG_TENS:  state <= DIG_ONES;
        DIG_ONES:  state <= PIX_READ;
        PIX_READ:  state <= PIX_WRITE;
        PIX_WRITE: begin
          if (stat.px_last) state <= RENDER_DONE;
          else state <= PIX_READ;
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.fin = FIN_NONE;
    case (state)
      INIT, CLEAR: cmd.clr_step = 1'b1;
      CLEAR_DONE:  cmd.fin = FIN_CLEAR;
      READ:        cmd.rd_read = 1'b1;
      READ_DONE:   cmd.fin = FIN_READ;
      IGNORE:      cmd.fin = FIN_IGNORED;
      DIG_HUND:    cmd.dig_hund = 1'b1;
      DIG_REM:     cmd.dig_rem = 1'b1;
      DIG_TENS:    cmd.dig_tens = 1'b1;
      DIG_ONES:    cmd.dig_ones = 1'b1;
      PIX_READ:    cmd.px_rd = 1'b1;
      PIX_WRITE:   cmd.px_wr = 1'b1;
      RENDER_DONE: cmd.fin = FIN_RENDER;
      default:     cmd.fin = FIN_NONE;
    endcase
  end

  assign busy = (state != IDLE);

endmodule

`default_nettype wire

[hdl/dgfr_datapath.sv]
// dgfr_datapath: frame store, digit split, glyph cursor and result registers
// depends on dgfr_pkg
`default_nettype none

module dgfr_datapath #(
  parameter int ROW_BYTES       = dgfr_pkg::ROW_BYTES_DEFAULT,
  parameter int DISPLAY_COLUMNS = dgfr_pkg::DISPLAY_COLUMNS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [9:0]          number,
  input  wire logic [3:0]          text_row,
  input  wire logic [5:0]          column,
  input  wire logic [9:0]          read_address,
  input  wire logic                config_write,
  input  wire logic                config_data,
  input  wire dgfr_pkg::dgfr_cmd_t cmd,
  output dgfr_pkg::dgfr_stat_t     stat,
  output logic                     ready,
  output logic                     done,
  output logic [7:0]               read_byte,
  output logic [1:0]               status,
  output logic [1:0]               digits_drawn
);
  import dgfr_pkg::*;

  localparam int FRAME_BYTES = (DISPLAY_COLUMNS / 8) * ROW_BYTES;
  localparam int AW          = $clog2(FRAME_BYTES);
  localparam int IDX_W       = $clog2(16 * ROW_BYTES + FRAME_BYTES + 1024);

  logic [7:0]       mem [FRAME_BYTES];
  logic [7:0]       rdata;
  logic [AW-1:0]    sweep;
  logic [9:0]       n_reg;
  logic [9:0]       raddr_reg;
  logic [IDX_W-1:0] gbase;
  logic [3:0]       hund;
  logic [3:0]       tens;
  logic [3:0]       ones;
  logic [6:0]       rem;
  logic [1:0]       gpos;
  logic [3:0]       bidx;
  logic             half;
  logic             clip;

  logic [15:0]      hund_prod;
  logic [14:0]      tens_prod;
  logic [9:0]       rem_full;
  logic [6:0]       ones_full;
  logic [1:0]       ndig;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] ridx;
  logic             idx_ok;
  logic             ridx_ok;
  logic [3:0]       digit_cur;
  logic [7:0]       gbyte;
  logic [AW-1:0]    mem_raddr;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_we;
  logic             mem_re;

  // digit split by reciprocal multiply, exact for values below 1000
  assign hund_prod = 16'(n_reg) * 16'd41;
  assign rem_full  = n_reg - 10'(hund) * 10'd100;
  assign tens_prod = 15'(rem) * 15'd205;
  assign ones_full = rem - 7'(tens) * 7'd10;

  assign ndig = (n_reg > 10'd99) ? 2'd3 : ((n_reg > 10'd9) ? 2'd2 : 2'd1);

  assign idx    = gbase + IDX_W'(bidx) + (half ? IDX_W'(ROW_BYTES) : '0);
  assign ridx   = IDX_W'(raddr_reg);
  assign idx_ok = (idx < IDX_W'(FRAME_BYTES));
  assign ridx_ok = (ridx < IDX_W'(FRAME_BYTES));

  always_comb begin
    case (gpos)
      2'd0:    digit_cur = hund;
      2'd1:    digit_cur = tens;
      default: digit_cur = ones;
    endcase
  end

  assign gbyte = font_byte(digit_cur, half ? (5'(bidx) + 5'(GLYPH_W)) : 5'(bidx));

  assign mem_re    = cmd.px_rd | cmd.rd_read;
  assign mem_raddr = cmd.px_rd ? idx[AW-1:0] : ridx[AW-1:0];
  assign mem_we    = cmd.clr_step | (cmd.px_wr & idx_ok);
  assign mem_waddr = cmd.clr_step ? sweep : idx[AW-1:0];
  assign mem_wdata = cmd.clr_step ? 8'd0 : (rdata | gbyte);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rdata <= mem[mem_raddr];
  end

  assign stat.sweep_last = (sweep == AW'(FRAME_BYTES - 1));
  assign stat.px_last    = half && (bidx == 4'(GLYPH_W - 1)) && (gpos == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.clr_step) begin
      if (stat.sweep_last) sweep <= '0;
      else sweep <= sweep + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= 1'b0;
    end else if (config_write) begin
      ready <= config_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n_reg     <= number;
      raddr_reg <= read_address;
      gbase     <= IDX_W'(text_row) * IDX_W'(ROW_BYTES) + IDX_W'(column);
    end
    if (cmd.dig_hund) begin
      hund <= hund_prod[15:12];
      gpos <= 2'd3 - ndig;
      bidx <= '0;
      half <= 1'b0;
      clip <= 1'b0;
    end
    if (cmd.dig_rem) rem <= rem_full[6:0];
    if (cmd.dig_tens) tens <= tens_prod[14:11];
    if (cmd.dig_ones) ones <= ones_full[3:0];
    if (cmd.px_wr) begin
      if (!idx_ok) clip <= 1'b1;
      if (!half) begin
        half <= 1'b1;
      end else begin
        half <= 1'b0;
        if (bidx == 4'(GLYPH_W - 1)) begin
          bidx  <= '0;
          gpos  <= gpos + 2'd1;
          gbase <= gbase + IDX_W'(GLYPH_W);
        end else begin
          bidx <= bidx + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.fin != FIN_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.fin)
      FIN_IGNORED: begin
        read_byte    <= 8'd0;
        status       <= STATUS_IGNORED;
        digits_drawn <= 2'd0;
      end
      FIN_CLEAR: begin
        read_byte    <= 8'd0;
        status       <= STATUS_DONE;
        digits_drawn <= 2'd0;
      end
      FIN_READ: begin
        read_byte    <= ridx_ok ? rdata : 8'd0;
        status       <= ridx_ok ? STATUS_DONE : STATUS_CLIPPED;
        digits_drawn <= 2'd0;
      end
      FIN_RENDER: begin
        read_byte    <= 8'd0;
        status       <= clip ? STATUS_CLIPPED : STATUS_DONE;
        digits_drawn <= ndig;
      end
      default: begin
        read_byte    <= read_byte;
        status       <= status;
        digits_drawn <= digits_drawn;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/decimal_glyph_framebuffer_render.sv]
// decimal_glyph_framebuffer_render: top level, joins controller and datapath
// depends on dgfr_pkg, dgfr_ctrl, dgfr_datapath
//
// A request is taken when start is high and busy is low. Its one result
// appears on read_byte, status and digits_drawn with done high for a single
// cycle; the receiver cannot stall, so capture it then. After reset, busy
// stays high while the store of FRAME_BYTES bytes (1024 by default) is
// zeroed one byte per cycle. In a render each glyph byte is a read, then a
// write of the old byte ORed with the font byte, on a store with one read
// port and one write port. done is high in the first cycle with busy low,
// and the next request may be given in that cycle.
`default_nettype none

module decimal_glyph_framebuffer_render #(
  parameter int ROW_BYTES       = dgfr_pkg::ROW_BYTES_DEFAULT,
  parameter int DISPLAY_COLUMNS = dgfr_pkg::DISPLAY_COLUMNS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] op,
  input  wire logic [9:0] number,
  input  wire logic [3:0] text_row,
  input  wire logic [5:0] column,
  input  wire logic [9:0] read_address,
  input  wire logic       config_write,
  input  wire logic       config_data,
  output logic            done,
  output logic [7:0]      read_byte,
  output logic [1:0]      status,
  output logic [1:0]      digits_drawn
);
  import dgfr_pkg::*;

  dgfr_cmd_t  cmd;
  dgfr_stat_t stat;
  logic       accept;
  logic       ready;

  assign accept = start & ~busy;

  dgfr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .op     (op),
    .number (number),
    .ready  (ready),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  dgfr_datapath #(
    .ROW_BYTES       (ROW_BYTES),
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .number       (number),
    .text_row     (text_row),
    .column       (column),
    .read_address (read_address),
    .config_write (config_write),
    .config_data  (config_data),
    .cmd          (cmd),
    .stat         (stat),
    .ready        (ready),
    .done         (done),
    .read_byte    (read_byte),
    .status       (status),
    .digits_drawn (digits_drawn)
  );

endmodule

`default_nettype wire
